// ===== hdl/triangle_box_overlap_test_top_macros.svh =====
// Assertion macros shared by the checker
`ifndef TRIANGLE_BOX_OVERLAP_TEST_TOP_MACROS_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_TOP_MACROS_SVH
// Assert a property on the rising clock, silent during reset
`define TBO_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
// Assert a property that must also hold while reset is high
`define TBO_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`endif

// ===== hdl/tbo_pkg.sv =====
// Shared types and constants for the triangle/box overlap test
package tbo_pkg;
  localparam int NUM_REGS = 6;
  localparam int REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW_X = 3'd0, REG_LOW_Y = 3'd1, REG_LOW_Z = 3'd2,
    REG_HIGH_X = 3'd3, REG_HIGH_Y = 3'd4, REG_HIGH_Z = 3'd5
  } reg_idx_t;
endpackage

// ===== hdl/tbo_if.sv =====
// Handshake channel interfaces
interface tbo_tri_if #(parameter int COORD_WIDTH = 24) (input logic clk);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] vertex0_x, vertex0_y, vertex0_z;
  logic signed [COORD_WIDTH-1:0] vertex1_x, vertex1_y, vertex1_z;
  logic signed [COORD_WIDTH-1:0] vertex2_x, vertex2_y, vertex2_z;
  modport source (output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                  vertex1_z, vertex2_x, vertex2_y, vertex2_z, input ready);
  modport sink (input valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                vertex1_z, vertex2_x, vertex2_y, vertex2_z, output ready);
endinterface

interface tbo_res_if (input logic clk);
  logic valid;
  logic ready;
  logic overlaps;
  modport source (output valid, overlaps, input ready);
  modport sink (input valid, overlaps, output ready);
endinterface

interface tbo_cfg_if #(parameter int COORD_WIDTH = 24) (input logic clk);
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [COORD_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/tbo_sep.sv =====
// Normal-axis projections and box radius, split multipliers over two register stages
module tbo_sep #(
  parameter int PW = 26,
  parameter int NW = 51
) (
  input  logic clk,
  input  logic en,
  input  logic signed [PW-1:0] p [3][3],
  input  logic signed [PW-1:0] h [3],
  input  logic signed [NW-1:0] ax [3],
  input  logic signed [NW-1:0] axa [3],
  output logic signed [PW+NW+1:0] s [3],
  output logic signed [PW+NW+1:0] r
);
  localparam int LO_W = NW / 2;
  localparam int HI_W = NW - LO_W;
  localparam int QW   = PW + LO_W + 3;
  localparam int DW   = PW + NW + 2;

  // cut each axis component into a signed upper part and an unsigned lower part
  logic signed [LO_W:0]   ax_lo [3];
  logic signed [LO_W:0]   axa_lo [3];
  logic signed [HI_W-1:0] ax_hi [3];
  logic signed [HI_W-1:0] axa_hi [3];
  logic signed [QW-1:0]   s_lo [3];
  logic signed [QW-1:0]   s_hi [3];
  logic signed [QW-1:0]   r_lo, r_hi;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ax_lo[c]  = {1'b0, ax[c][LO_W-1:0]};
      ax_hi[c]  = ax[c][NW-1:LO_W];
      axa_lo[c] = {1'b0, axa[c][LO_W-1:0]};
      axa_hi[c] = axa[c][NW-1:LO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s_lo[i] <= QW'(p[i][0]) * QW'(ax_lo[0]) + QW'(p[i][1]) * QW'(ax_lo[1])
                 + QW'(p[i][2]) * QW'(ax_lo[2]);
        s_hi[i] <= QW'(p[i][0]) * QW'(ax_hi[0]) + QW'(p[i][1]) * QW'(ax_hi[1])
                 + QW'(p[i][2]) * QW'(ax_hi[2]);
      end
      r_lo <= QW'(h[0]) * QW'(axa_lo[0]) + QW'(h[1]) * QW'(axa_lo[1])
            + QW'(h[2]) * QW'(axa_lo[2]);
      r_hi <= QW'(h[0]) * QW'(axa_hi[0]) + QW'(h[1]) * QW'(axa_hi[1])
            + QW'(h[2]) * QW'(axa_hi[2]);
      // recombine the halves one stage later
      for (int i = 0; i < 3; i++)
        s[i] <= (DW'(s_hi[i]) <<< LO_W) + DW'(s_lo[i]);
      r <= (DW'(r_hi) <<< LO_W) + DW'(r_lo);
    end
  end
endmodule

// ===== hdl/triangle_box_overlap_test_top.sv =====
// Throughput one triangle per cycle while the output register is empty or being drained.
// The pipeline advances whenever the output register is empty or being drained,
// so a stall holds every stage and nothing is lost or repeated.
// Box registers and all valid bits clear on synchronous reset; payload stages do not.
// Stages: doubling/edges, box axes and edge products, normal and cross projections,
// cross compare and split normal products, normal recombine, normal compare.
module triangle_box_overlap_test_top
  import tbo_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input logic clk,
  input logic rst,
  tbo_tri_if.sink in_tri,
  tbo_res_if.source out_res,
  tbo_cfg_if.sink cfg
);
  localparam int W  = COORD_WIDTH;
  localparam int PW = W + 2;      // doubled point minus doubled centre
  localparam int EW = W + 1;      // edge
  localparam int NW = 2*EW + 1;   // normal component
  localparam int DW = PW + NW + 2; // normal projection
  localparam int CW = PW + EW + 2; // cross projection

  logic signed [W-1:0] breg [NUM_REGS];
  logic advance;
  logic [5:0] vld;
  assign advance = !out_res.valid || out_res.ready;
  assign in_tri.ready = advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) breg[i] <= '0;
    end else if (cfg.valid && cfg.index < 3'(NUM_REGS)) begin
      breg[cfg.index] <= cfg.data;
    end
  end

  // stage 1: centred doubled points, half extents, edges
  logic signed [PW-1:0] p [3][3];
  logic signed [PW-1:0] hh [3];
  logic signed [EW-1:0] e [3][3];
  logic signed [W-1:0] vin [3][3];
  always_comb begin
    vin[0][0] = in_tri.vertex0_x; vin[0][1] = in_tri.vertex0_y; vin[0][2] = in_tri.vertex0_z;
    vin[1][0] = in_tri.vertex1_x; vin[1][1] = in_tri.vertex1_y; vin[1][2] = in_tri.vertex1_z;
    vin[2][0] = in_tri.vertex2_x; vin[2][1] = in_tri.vertex2_y; vin[2][2] = in_tri.vertex2_z;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        hh[k] <= PW'(breg[k+3]) - PW'(breg[k]);
        for (int i = 0; i < 3; i++) begin
          p[i][k] <= (PW'(vin[i][k]) <<< 1) - PW'(breg[k]) - PW'(breg[k+3]);
          e[i][k] <= EW'(vin[(i+1)%3][k]) - EW'(vin[i][k]);
        end
      end
    end
  end

  // stage 2: box-axis verdict, edge products for the normal
  logic signed [2*EW-1:0] m [6];
  logic signed [PW-1:0] p2 [3][3];
  logic signed [PW-1:0] h2 [3];
  logic signed [EW-1:0] e2 [3][3];
  logic sep_box_c;
  logic sep_box;
  always_comb begin
    sep_box_c = 1'b0;
    for (int k = 0; k < 3; k++)
      if ((p[0][k] > hh[k] && p[1][k] > hh[k] && p[2][k] > hh[k]) ||
          (p[0][k] < -hh[k] && p[1][k] < -hh[k] && p[2][k] < -hh[k]))
        sep_box_c = 1'b1;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      m[0] <= e[0][1]*e[1][2]; m[1] <= e[0][2]*e[1][1];
      m[2] <= e[0][2]*e[1][0]; m[3] <= e[0][0]*e[1][2];
      m[4] <= e[0][0]*e[1][1]; m[5] <= e[0][1]*e[1][0];
      p2 <= p; h2 <= hh; e2 <= e;
      sep_box <= sep_box_c;
    end
  end

  // stage 3: normal and cross projections
  logic signed [NW-1:0] n [3];
  always_comb begin
    n[0] = NW'(m[0]) - NW'(m[1]);
    n[1] = NW'(m[2]) - NW'(m[3]);
    n[2] = NW'(m[4]) - NW'(m[5]);
  end
  logic signed [NW-1:0] n3 [3];
  logic signed [NW-1:0] na3 [3];
  logic signed [PW-1:0] p3 [3][3];
  logic signed [PW-1:0] h3 [3];
  logic signed [CW-1:0] dc [9][3];
  logic signed [CW-1:0] rc [9];
  logic zc [9];
  logic sep_box3;
  always_ff @(posedge clk) begin
    if (advance) begin
      sep_box3 <= sep_box;
      p3 <= p2; h3 <= h2;
      for (int c = 0; c < 3; c++) begin
        n3[c]  <= n[c];
        na3[c] <= n[c] < 0 ? -n[c] : n[c];
      end
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 3; j++) begin
          // axis = (-e[q], e[p]) on components p, q
          zc[a*3+j] <= (e2[j][(a+2)%3] == 0) && (e2[j][(a+1)%3] == 0);
          rc[a*3+j] <= CW'(h2[(a+1)%3]) *
                         CW'(e2[j][(a+2)%3] < 0 ? -e2[j][(a+2)%3] : e2[j][(a+2)%3])
                     + CW'(h2[(a+2)%3]) *
                         CW'(e2[j][(a+1)%3] < 0 ? -e2[j][(a+1)%3] : e2[j][(a+1)%3]);
          for (int i = 0; i < 3; i++)
            dc[a*3+j][i] <= CW'(p2[i][(a+2)%3])*CW'(e2[j][(a+1)%3])
                          - CW'(p2[i][(a+1)%3])*CW'(e2[j][(a+2)%3]);
        end
      end
    end
  end

  // stages 4 and 5: cross verdict, normal projections over split multipliers
  logic signed [DW-1:0] dn [3];
  logic signed [DW-1:0] rn;
  logic sep_cross;
  logic sep4, sep5;
  always_comb begin
    sep_cross = sep_box3;
    for (int t = 0; t < 9; t++)
      if (!zc[t] && ((dc[t][0] > rc[t] && dc[t][1] > rc[t] && dc[t][2] > rc[t]) ||
          (dc[t][0] < -rc[t] && dc[t][1] < -rc[t] && dc[t][2] < -rc[t])))
        sep_cross = 1'b1;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      sep4 <= sep_cross;
      sep5 <= sep4;
    end
  end

  tbo_sep #(.PW(PW), .NW(NW)) u_sep (
    .clk(clk), .en(advance), .p(p3), .h(h3), .ax(n3), .axa(na3), .s(dn), .r(rn)
  );

  // stage 6: normal compare into the output register
  logic sep_norm;
  assign sep_norm = (dn[0] > rn && dn[1] > rn && dn[2] > rn) ||
                    (dn[0] < -rn && dn[1] < -rn && dn[2] < -rn);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[4:0], in_tri.valid};
    end
  end
  assign out_res.valid = vld[5];
  always_ff @(posedge clk) begin
    if (advance) out_res.overlaps <= !(sep5 || sep_norm);
  end
endmodule

// ===== hdl/tbo_checker.sv =====
// Port-level checker for the overlap test, bound to the top level
`include "triangle_box_overlap_test_top_macros.svh"
module tbo_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic overlaps
);
  `TBO_ASSERT(stall_holds, out_valid && !out_ready |=> out_valid && $stable(overlaps))
  `TBO_ASSERT(ready_when_free, !out_valid |-> in_ready)
  `TBO_ASSERT(stall_blocks_input, out_valid && !out_ready |-> !in_ready)
  `TBO_ASSERT_ALWAYS(reset_empties, rst |=> !out_valid)
endmodule

bind triangle_box_overlap_test_top tbo_checker u_tbo_checker (
  .clk(clk), .rst(rst), .in_ready(in_tri.ready),
  .out_valid(out_res.valid), .out_ready(out_res.ready), .overlaps(out_res.overlaps)
);
